### rtl/core/ppc_pkg.sv
// Shared types and constants for the payload protocol classifier.
// Holds the protocol codes, the header-check hit vector and the magic numbers.
// No dependencies.
package ppc_pkg;

  // Stream widths: head bytes, tail bytes and length packed into whole bytes.
  localparam int HeadWidth = 64;
  localparam int TailWidth = 32;
  localparam int LenWidth  = 12;
  localparam int InWidth   = 112;
  localparam int CodeWidth = 4;
  localparam int OutWidth  = 8;

  // Protocol codes on the result beat.
  localparam logic [CodeWidth-1:0] CodeUnknown = 4'd0;
  localparam logic [CodeWidth-1:0] CodeHttp    = 4'd1;
  localparam logic [CodeWidth-1:0] CodeHttp2   = 4'd2;
  localparam logic [CodeWidth-1:0] CodeMysql   = 4'd3;
  localparam logic [CodeWidth-1:0] CodeCql     = 4'd4;
  localparam logic [CodeWidth-1:0] CodePgsql   = 4'd5;
  localparam logic [CodeWidth-1:0] CodeDns     = 4'd6;
  localparam logic [CodeWidth-1:0] CodeRedis   = 4'd7;
  localparam logic [CodeWidth-1:0] CodeNats    = 4'd8;
  localparam logic [CodeWidth-1:0] CodeMongo   = 4'd9;
  localparam logic [CodeWidth-1:0] CodeKafka   = 4'd10;
  localparam logic [CodeWidth-1:0] CodeAmqp    = 4'd11;
  localparam logic [CodeWidth-1:0] CodeTls     = 4'd12;

  // Limits and magic values of the binary header checks.
  localparam logic [31:0] PgStartupVersion = 32'h0003_0000;
  localparam logic [31:0] PgMaxMsgLen      = 32'h0010_0000;
  localparam logic [31:0] MongoMaxMsgLen   = 32'h0200_0000;
  localparam logic [31:0] KafkaMaxMsgLen   = 32'h0640_0000;
  localparam logic [31:0] MongoOpReply     = 32'd1;
  localparam logic [31:0] MongoOpQuery     = 32'd2004;
  localparam logic [31:0] MongoOpMsg       = 32'd2013;
  localparam logic [15:0] KafkaMaxApiKey   = 16'd67;
  localparam logic [15:0] KafkaMaxApiVer   = 16'd15;

  // One hit flag per binary header check, length gating already applied.
  typedef struct packed {
    logic tls;
    logic amqp;
    logic mysql;
    logic cql;
    logic pgsql;
    logic dns;
    logic mongo;
    logic kafka;
  } hdr_hits_t;

endpackage

### rtl/core/ppc_text_lane.sv
// Text prefix lane: HTTP, HTTP/2, NATS and Redis prefixes keyed on byte 0.
// Depends on ppc_pkg for the protocol codes.
module ppc_text_lane (
  input  logic [ppc_pkg::HeadWidth-1:0] head_bytes_i,
  input  logic [ppc_pkg::LenWidth-1:0]  payload_len_i,
  output logic [ppc_pkg::CodeWidth-1:0] text_code_o
);

  logic [63:0] lead;
  logic        digit1;
  logic [ppc_pkg::CodeWidth-1:0] code;

  // Byte 0 goes to the top so that string literals compare directly.
  assign lead = {head_bytes_i[7:0],   head_bytes_i[15:8],  head_bytes_i[23:16],
                 head_bytes_i[31:24], head_bytes_i[39:32], head_bytes_i[47:40],
                 head_bytes_i[55:48], head_bytes_i[63:56]};

  assign digit1 = (lead[55:48] >= "0") && (lead[55:48] <= "9");

  // Prefix match per leading character, first match within a character wins.
  always_comb begin
    code = ppc_pkg::CodeUnknown;
    case (lead[63:56])
      "G": begin
        if (lead[63:32] == "GET ") code = ppc_pkg::CodeHttp;
      end
      "P": begin
        if (lead[63:32] == "PRI ") code = ppc_pkg::CodeHttp2;
        else if (payload_len_i >= 12'd5 && lead[63:24] == "POST ") code = ppc_pkg::CodeHttp;
        else if (lead[63:32] == "PUT ") code = ppc_pkg::CodeHttp;
        else if (payload_len_i >= 12'd6 && lead[63:16] == "PATCH ") code = ppc_pkg::CodeHttp;
        else if (lead[63:32] == "PUB ") code = ppc_pkg::CodeNats;
        else if (lead[63:32] == "PING") code = ppc_pkg::CodeNats;
        else if (lead[63:32] == "PONG") code = ppc_pkg::CodeNats;
      end
      "H": begin
        if (payload_len_i >= 12'd6 && lead[63:24] == "HTTP/") begin
          code = (lead[23:16] == "2") ? ppc_pkg::CodeHttp2 : ppc_pkg::CodeHttp;
        end else if (payload_len_i >= 12'd5 && lead[63:24] == "HEAD ") begin
          code = ppc_pkg::CodeHttp;
        end
      end
      "D": begin
        if (payload_len_i >= 12'd7 && lead[63:8] == "DELETE ") code = ppc_pkg::CodeHttp;
      end
      "O": begin
        if (payload_len_i >= 12'd8 && lead == "OPTIONS ") code = ppc_pkg::CodeHttp;
      end
      "C": begin
        if (payload_len_i >= 12'd8 && lead == "CONNECT ") code = ppc_pkg::CodeHttp;
      end
      "I": begin
        if (payload_len_i >= 12'd5 && lead[63:24] == "INFO ") code = ppc_pkg::CodeNats;
      end
      "M": begin
        if (lead[63:32] == "MSG ") code = ppc_pkg::CodeNats;
      end
      "S": begin
        if (lead[63:32] == "SUB ") code = ppc_pkg::CodeNats;
      end
      "+": begin
        if (lead[55:40] == "OK") code = ppc_pkg::CodeNats;
        else if (digit1) code = ppc_pkg::CodeRedis;
      end
      "-": begin
        if (lead[55:32] == "ERR") code = ppc_pkg::CodeNats;
        else if (digit1) code = ppc_pkg::CodeRedis;
      end
      "*", "$", ":": begin
        if (digit1) code = ppc_pkg::CodeRedis;
      end
      default: code = ppc_pkg::CodeUnknown;
    endcase
  end

  // Every check needs at least four bytes.
  assign text_code_o = (payload_len_i >= 12'd4) ? code : ppc_pkg::CodeUnknown;

endmodule

### rtl/core/ppc_hdr_lane.sv
// Binary header lane: TLS, AMQP, MySQL, CQL, PostgreSQL, DNS, MongoDB, Kafka.
// Depends on ppc_pkg for the hit vector type and the magic numbers.
module ppc_hdr_lane (
  input  logic [ppc_pkg::HeadWidth-1:0] head_bytes_i,
  input  logic [ppc_pkg::TailWidth-1:0] tail_bytes_i,
  input  logic [ppc_pkg::LenWidth-1:0]  payload_len_i,
  output ppc_pkg::hdr_hits_t            hits_o
);

  logic [7:0]  b0, b1, b2, b3, b4, b5, b6, b7;
  logic [31:0] be_0_3, be_1_4, be_4_7, le_0_3;
  logic [15:0] be_0_1, be_4_5, be_6_7;
  logic [3:0]  dns_op;
  logic        ok4, ok5, ok8, ok9, ok12, ok16;

  assign {b7, b6, b5, b4, b3, b2, b1, b0} = head_bytes_i;

  // Multi-byte views of the header in both byte orders.
  assign be_0_3 = {b0, b1, b2, b3};
  assign be_1_4 = {b1, b2, b3, b4};
  assign be_4_7 = {b4, b5, b6, b7};
  assign le_0_3 = {b3, b2, b1, b0};
  assign be_0_1 = {b0, b1};
  assign be_4_5 = {b4, b5};
  assign be_6_7 = {b6, b7};
  assign dns_op = b4[6:3];

  // Length gates.
  assign ok4  = payload_len_i >= 12'd4;
  assign ok5  = payload_len_i >= 12'd5;
  assign ok8  = payload_len_i >= 12'd8;
  assign ok9  = payload_len_i >= 12'd9;
  assign ok12 = payload_len_i >= 12'd12;
  assign ok16 = payload_len_i >= 12'd16;

  // Each check is evaluated independently; the merge stage applies priority.
  always_comb begin
    hits_o.tls   = ok4 && b0 == 8'h16 && b1 == 8'h03 && b2 >= 8'h01 && b2 <= 8'h04;
    hits_o.amqp  = ok4 && be_0_3 == "AMQP";
    hits_o.mysql = ok5 &&
                   ((b3 == 8'h00 &&
                     (b4 == 8'h0a || b4 == 8'h01 || b4 == 8'h02 || b4 == 8'h03 ||
                      b4 == 8'h04 || b4 == 8'h16 || b4 == 8'h17 || b4 == 8'h19)) ||
                    (b3 != 8'h00 && b3 < 8'd10 &&
                     (b4 == 8'h00 || b4 == 8'hFE || b4 == 8'hFF)));
    hits_o.cql   = ok9 &&
                   (b0 == 8'h03 || b0 == 8'h04 || b0 == 8'h05 ||
                    b0 == 8'h83 || b0 == 8'h84 || b0 == 8'h85) &&
                   b4 <= 8'h10;
    hits_o.pgsql = (ok8 && be_4_7 == ppc_pkg::PgStartupVersion) ||
                   (ok5 &&
                    (b0 == "Q" || b0 == "R" || b0 == "T" || b0 == "X" ||
                     b0 == "E" || b0 == "Z" || b0 == "K") &&
                    be_1_4 >= 32'd4 && be_1_4 <= ppc_pkg::PgMaxMsgLen);
    hits_o.dns   = ok12 && be_0_1 >= 16'd12 && be_0_1 < 16'd4096 &&
                   dns_op <= 4'd2 && be_6_7 >= 16'd1 && be_6_7 <= 16'd16;
    hits_o.mongo = ok16 && le_0_3 >= 32'd16 && le_0_3 <= ppc_pkg::MongoMaxMsgLen &&
                   (tail_bytes_i == ppc_pkg::MongoOpReply ||
                    tail_bytes_i == ppc_pkg::MongoOpQuery ||
                    tail_bytes_i == ppc_pkg::MongoOpMsg);
    hits_o.kafka = ok8 && be_0_3 >= 32'd4 && be_0_3 <= ppc_pkg::KafkaMaxMsgLen &&
                   be_4_5 <= ppc_pkg::KafkaMaxApiKey && be_6_7 <= ppc_pkg::KafkaMaxApiVer;
  end

endmodule

### rtl/core/ppc_merge.sv
// Merge stage: combines the lane results into one code by fixed priority.
// Depends on ppc_pkg for the hit vector type and the protocol codes.
module ppc_merge (
  input  logic [ppc_pkg::CodeWidth-1:0] text_code_i,
  input  ppc_pkg::hdr_hits_t            hits_i,
  output logic [ppc_pkg::CodeWidth-1:0] code_o
);

  // Highest priority first: TLS, AMQP, text prefixes, then binary headers.
  always_comb begin
    if (hits_i.tls)                            code_o = ppc_pkg::CodeTls;
    else if (hits_i.amqp)                      code_o = ppc_pkg::CodeAmqp;
    else if (text_code_i != ppc_pkg::CodeUnknown) code_o = text_code_i;
    else if (hits_i.mysql)                     code_o = ppc_pkg::CodeMysql;
    else if (hits_i.cql)                       code_o = ppc_pkg::CodeCql;
    else if (hits_i.pgsql)                     code_o = ppc_pkg::CodePgsql;
    else if (hits_i.dns)                       code_o = ppc_pkg::CodeDns;
    else if (hits_i.mongo)                     code_o = ppc_pkg::CodeMongo;
    else if (hits_i.kafka)                     code_o = ppc_pkg::CodeKafka;
    else                                       code_o = ppc_pkg::CodeUnknown;
  end

endmodule

### rtl/core/payload_protocol_classifier.sv
// Payload protocol classifier, top level.
// An accepted input beat passes the lane result register, then the output register, to its result beat.
// Throughput: one beat per cycle while the output is not stalled; the lane register and the output register
// each advance whenever the stage after them is empty or being drained.
// Reset clears the two stage valid flags only; payload registers are not reset.
// Depends on ppc_pkg, ppc_text_lane, ppc_hdr_lane and ppc_merge.
module payload_protocol_classifier (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // Fields from bit 0 up: head_bytes[63:0], tail_bytes[95:64],
  // payload_len[107:96], zero fill[111:108].
  input  logic [ppc_pkg::InWidth-1:0]  s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // Fields from bit 0 up: protocol_code[3:0], zero fill[7:4].
  output logic [ppc_pkg::OutWidth-1:0] m_axis_tdata
);

  logic [ppc_pkg::HeadWidth-1:0] head_bytes;
  logic [ppc_pkg::TailWidth-1:0] tail_bytes;
  logic [ppc_pkg::LenWidth-1:0]  payload_len;
  logic [ppc_pkg::CodeWidth-1:0] text_code;
  ppc_pkg::hdr_hits_t            hits;
  logic [ppc_pkg::CodeWidth-1:0] merged_code;

  logic                          s1_valid_q, s1_valid_d;
  logic [ppc_pkg::CodeWidth-1:0] s1_text_q;
  ppc_pkg::hdr_hits_t            s1_hits_q;
  logic                          out_valid_q, out_valid_d;
  logic [ppc_pkg::CodeWidth-1:0] out_code_q;
  logic                          s1_ready, out_ready;

  // Unpack the input beat.
  assign head_bytes  = s_axis_tdata[63:0];
  assign tail_bytes  = s_axis_tdata[95:64];
  assign payload_len = s_axis_tdata[107:96];

  // Lanes work on the same beat side by side.
  ppc_text_lane u_text_lane (
    .head_bytes_i  (head_bytes),
    .payload_len_i (payload_len),
    .text_code_o   (text_code)
  );

  ppc_hdr_lane u_hdr_lane (
    .head_bytes_i  (head_bytes),
    .tail_bytes_i  (tail_bytes),
    .payload_len_i (payload_len),
    .hits_o        (hits)
  );

  // Each stage advances when the stage after it can take its content.
  assign out_ready     = !out_valid_q || m_axis_tready;
  assign s1_ready      = !s1_valid_q || out_ready;
  assign s_axis_tready = s1_ready;
  assign s1_valid_d    = s1_ready ? s_axis_tvalid : s1_valid_q;
  assign out_valid_d   = out_ready ? s1_valid_q : out_valid_q;

  // Stage valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Lane result register.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s1_ready) begin
      s1_text_q <= text_code;
      s1_hits_q <= hits;
    end
  end

  ppc_merge u_merge (
    .text_code_i (s1_text_q),
    .hits_i      (s1_hits_q),
    .code_o      (merged_code)
  );

  // Output register.
  always_ff @(posedge clk_i) begin
    if (s1_valid_q && out_ready) begin
      out_code_q <= merged_code;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(ppc_pkg::OutWidth - ppc_pkg::CodeWidth){1'b0}}, out_code_q};

`ifndef SYNTHESIS
  // A full lane register facing a stalled output must keep its content.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !m_axis_tready |=>
      s1_valid_q && $stable(s1_text_q) && $stable(s1_hits_q))
    else $error("lane register changed while the output was stalled");

  // An empty lane register always lets a beat in.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> s_axis_tready)
    else $error("input stalled with an empty lane register");

  // Only defined protocol codes leave the block.
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[ppc_pkg::CodeWidth-1:0] <= ppc_pkg::CodeTls)
    else $error("protocol code out of range");

  // A finished result moves to the output when the output is free.
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_valid_q |=> out_valid_q)
    else $error("result did not advance into a free output register");
`endif

endmodule
